/* rtl/core/ufr_pkg.sv */
// Shared types and constants for the serial frame rewrapper.
package ufr_pkg;

   localparam logic [7:0] HEAD_BYTE = 8'hAA;
   localparam logic [7:0] CTRL_BYTE = 8'hD3;
   localparam logic [7:0] ZERO_BYTE = 8'h00;

   // Sum of the fixed header bytes 0xD3, 0x00 and 0xAA, modulo 256.
   localparam logic [7:0] HDR_FIXED_SUM = 8'(CTRL_BYTE + ZERO_BYTE + HEAD_BYTE);

   // Amount added to the frame length for the outgoing length field.
   localparam logic [8:0] LEN_EXTRA = 9'd4;
   // Shortest accepted frame length.
   localparam logic [7:0] MIN_LEN   = 8'd4;
   // Difference between frame length and payload byte count.
   localparam logic [7:0] LEN_TRIM  = 8'd3;

   // Depth of the command queue between front and back.
   localparam int unsigned CMD_DEPTH = 4;
   localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Index of the final word of an outgoing header, which has eight words.
   localparam logic [2:0] HDR_LAST_IDX = 3'd7;

   // Register word index of node_id.
   localparam logic REG_NODE_ID = 1'b0;

   // Command kinds passed from front to back.
   localparam logic CMD_DATA   = 1'b0;
   localparam logic CMD_HEADER = 1'b1;

   // One command: a header to expand, or a payload word with optional check word.
   typedef struct packed {
      logic       kind;
      logic       last;
      logic [7:0] data;
      logic [7:0] check;
   } cmd_type;

endpackage

/* rtl/core/uart_frame_rewrapper.sv */
// Top level of the serial frame rewrapper with its register port.
// Received serial words go in through push/full and are accepted at one per cycle
// while the command queue (four entries) has room; the front end classifies each
// word at once. Outgoing words come out through empty/pop at one per cycle, while
// pop is given and commands are waiting, from the back end's output register: a
// frame header expands into eight output words, a payload word into one, and the
// final payload word into two (itself and the check word). When the back end is
// idle, each command passes the queue, then the output register, to the ports.
// The node_id register (word 0) should only be written while no frame is in flight.
module uart_frame_rewrapper import ufr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_frame_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [7:0] node_id_reg_ff, node_id_reg_in;
   logic       accept;
   logic       cmd_push;
   cmd_type    cmd_wr;
   cmd_type    cmd_rd;
   logic       cmd_pop;
   logic       cmd_ready;

   assign pready = 1'b1;
   assign accept = push && !full;

   // Register write and read decode.
   always_comb begin
      node_id_reg_in = node_id_reg_ff;
      if (psel && penable && pwrite && paddr[2] == REG_NODE_ID) begin
         node_id_reg_in = pwdata[7:0];
      end
   end

   assign prdata = (paddr[2] == REG_NODE_ID) ? {24'b0, node_id_reg_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_reg_ff <= '0;
      end else begin
         node_id_reg_ff <= node_id_reg_in;
      end
   end

   ufr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .node_id  (node_id_reg_ff),
      .cmd_push (cmd_push),
      .cmd_word (cmd_wr)
   );

   ufr_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (cmd_push),
      .wr_word   (cmd_wr),
      .rd_en     (cmd_pop),
      .rd_word   (cmd_rd),
      .full      (full),
      .not_empty (cmd_ready)
   );

   ufr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_word   (cmd_rd),
      .cmd_ready  (cmd_ready),
      .cmd_pop    (cmd_pop),
      .node_id    (node_id_reg_ff),
      .empty      (empty),
      .pop        (pop),
      .frame_byte (rsp_frame_byte),
      .frame_last (rsp_frame_last)
   );

endmodule

/* rtl/core/ufr_front.sv */
// Front end: parses received words and issues header and payload commands.
module ufr_front import ufr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic [7:0] node_id,
   output logic       cmd_push,
   output cmd_type    cmd_word
);

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_LEN_LO  = 3'd1;
   localparam logic [2:0] PH_LEN_HI  = 3'd2;
   localparam logic [2:0] PH_DISCARD = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] len_lo_ff, len_lo_in;
   logic [7:0] frame_len_ff, frame_len_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;

   logic [7:0] sum_next;
   logic [7:0] pos_next;
   logic       last_word;

   assign sum_next  = sum_ff + rx_byte;
   assign pos_next  = pos_ff + 8'd1;
   assign last_word = pos_next >= (frame_len_ff - LEN_TRIM);

   // Parser state machine; one command at most per accepted word.
   always_comb begin
      phase_in     = phase_ff;
      len_lo_in    = len_lo_ff;
      frame_len_in = frame_len_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      cmd_push     = 1'b0;
      cmd_word     = '0;
      if (accept) begin
         case (phase_ff)
            PH_LEN_LO: begin
               len_lo_in = rx_byte;
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               if (rx_byte != ZERO_BYTE || len_lo_ff == ZERO_BYTE) begin
                  phase_in = PH_HUNT;
               end else if (len_lo_ff < MIN_LEN) begin
                  frame_len_in = len_lo_ff;
                  phase_in     = PH_DISCARD;
               end else begin
                  frame_len_in   = len_lo_ff;
                  pos_in         = '0;
                  // The high length byte is zero here, so it adds nothing.
                  sum_in         = HDR_FIXED_SUM + node_id + len_lo_ff;
                  cmd_push       = 1'b1;
                  cmd_word.kind  = CMD_HEADER;
                  cmd_word.data  = len_lo_ff;
                  phase_in       = PH_PAYLOAD;
               end
            end
            PH_DISCARD: begin
               phase_in = PH_HUNT;
            end
            PH_PAYLOAD: begin
               cmd_push       = 1'b1;
               cmd_word.kind  = CMD_DATA;
               cmd_word.data  = rx_byte;
               cmd_word.last  = last_word;
               cmd_word.check = sum_next - LEN_TRIM;
               sum_in         = sum_next;
               if (last_word) begin
                  pos_in   = '0;
                  phase_in = PH_HUNT;
               end else begin
                  pos_in = pos_next;
               end
            end
            default: begin
               phase_in = (rx_byte == HEAD_BYTE) ? PH_LEN_LO : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         len_lo_ff    <= '0;
         frame_len_ff <= '0;
         pos_ff       <= '0;
         sum_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         len_lo_ff    <= len_lo_in;
         frame_len_ff <= frame_len_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
      end
   end

endmodule

/* rtl/core/ufr_cmd_queue.sv */
// Short command queue between the front end and the back end.
module ufr_cmd_queue import ufr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_word,
   input  logic    rd_en,
   output cmd_type rd_word,
   output logic    full,
   output logic    not_empty
);

   cmd_type                store_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;

   assign full      = count_ff == CMD_CNT_W'(CMD_DEPTH);
   assign not_empty = count_ff != '0;
   assign rd_word   = store_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + CMD_PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + CMD_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

/* rtl/core/ufr_back.sv */
// Back end: expands commands into outgoing words held in an output register.
module ufr_back import ufr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd_word,
   input  logic       cmd_ready,
   output logic       cmd_pop,
   input  logic [7:0] node_id,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] frame_byte,
   output logic       frame_last
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   logic       load;
   logic [8:0] total_len;

   assign load      = cmd_ready && (!valid_ff || pop);
   assign total_len = {1'b0, cmd_word.data} + LEN_EXTRA;

   // Word selection within the current command.
   always_comb begin
      idx_in  = idx_ff;
      cmd_pop = 1'b0;
      byte_in = byte_ff;
      last_in = last_ff;
      if (load) begin
         last_in = 1'b0;
         if (cmd_word.kind == CMD_HEADER) begin
            case (idx_ff)
               3'd0:    byte_in = {7'b0, total_len[8]};
               3'd1:    byte_in = total_len[7:0];
               3'd2:    byte_in = CTRL_BYTE;
               3'd3:    byte_in = ZERO_BYTE;
               3'd4:    byte_in = node_id;
               3'd5:    byte_in = HEAD_BYTE;
               3'd6:    byte_in = cmd_word.data;
               default: byte_in = ZERO_BYTE;
            endcase
            if (idx_ff == HDR_LAST_IDX) begin
               cmd_pop = 1'b1;
               idx_in  = '0;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end else if (idx_ff == 3'd0) begin
            byte_in = cmd_word.data;
            if (cmd_word.last) begin
               idx_in = 3'd1;
            end else begin
               cmd_pop = 1'b1;
            end
         end else begin
            // Check word closing the frame.
            byte_in = cmd_word.check;
            last_in = 1'b1;
            cmd_pop = 1'b1;
            idx_in  = '0;
         end
      end
   end

   // Output register valid flag.
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign empty      = !valid_ff;
   assign frame_byte = byte_ff;
   assign frame_last = last_ff;

endmodule
